### src/rotation_matrix_to_quaternion_defines.svh
// Assertion macros for the rotation matrix to quaternion top level.
`ifndef ROTATION_MATRIX_TO_QUATERNION_DEFINES_SVH
`define ROTATION_MATRIX_TO_QUATERNION_DEFINES_SVH

// Same-cycle implication, checked outside reset.
`define RMQ_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, checked outside reset.
`define RMQ_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

### src/rmq_pkg.sv
// Shared widths, types and constants of the matrix to quaternion pipeline.
`timescale 1ns / 1ps
package rmq_pkg;

  localparam int FRAC_BITS = 14;
  localparam int DATA_W    = 16;
  // Radicand before scaling: 1 + d_big - d_other - d_other never exceeds 17 bits.
  localparam int RAD_W     = 17;
  localparam int SQ_IN_W   = RAD_W + FRAC_BITS - 2;
  localparam int ROOT_W    = (SQ_IN_W + 1) / 2;
  localparam int SQ_W      = SQ_IN_W + 2;
  // Off-diagonal sums and differences.
  localparam int P_W       = DATA_W + 1;
  localparam int DEN_W     = ROOT_W + 2;
  localparam int Q_W       = P_W + FRAC_BITS - 7;
  localparam int CMP_W     = DEN_W + Q_W;
  localparam int LAT       = 1 + ROOT_W + 1 + Q_W + 1;

  localparam logic [1:0] SEL_TRACE = 2'd0;
  localparam logic [1:0] SEL_X     = 2'd1;
  localparam logic [1:0] SEL_Y     = 2'd2;
  localparam logic [1:0] SEL_Z     = 2'd3;

  // Branch code and the three numerators that ride beside the root.
  typedef struct packed {
    logic [1:0]            sel;
    logic signed [P_W-1:0] pa;
    logic signed [P_W-1:0] pb;
    logic signed [P_W-1:0] pc;
  } side_t;

  // Branch code and root that ride beside the dividers.
  typedef struct packed {
    logic [1:0]        sel;
    logic [ROOT_W-1:0] h;
  } tail_t;

endpackage

### src/rmq_sqrt.sv
// Pipelined integer square root, one result bit per stage.
`timescale 1ns / 1ps
module rmq_sqrt (
  input  logic                          clk,
  input  logic                          en,
  input  logic [rmq_pkg::RAD_W-1:0]     rad,
  output logic [rmq_pkg::ROOT_W-1:0]    root
);

  logic [rmq_pkg::SQ_W-1:0]   rem_r  [rmq_pkg::ROOT_W];
  logic [rmq_pkg::ROOT_W-1:0] root_r [rmq_pkg::ROOT_W];

  genvar k;
  generate
    for (k = 0; k < rmq_pkg::ROOT_W; k++) begin : g_stage
      localparam int B = rmq_pkg::ROOT_W - 1 - k;
      logic [rmq_pkg::SQ_W-1:0]   rem_in;
      logic [rmq_pkg::ROOT_W-1:0] root_in;
      logic [rmq_pkg::SQ_W-1:0]   trial;

      // Stage input comes from the port or from the stage before.
      if (k == 0) begin : g_first
        assign rem_in  = rmq_pkg::SQ_W'(rad) << (rmq_pkg::FRAC_BITS - 2);
        assign root_in = '0;
      end else begin : g_next
        assign rem_in  = rem_r[k-1];
        assign root_in = root_r[k-1];
      end

      // Growth of the square when this root bit is set.
      assign trial = (rmq_pkg::SQ_W'(root_in) << (B + 1)) | (rmq_pkg::SQ_W'(1) << (2 * B));

      always_ff @(posedge clk) begin
        if (en) begin
          if (rem_in >= trial) begin
            rem_r[k]  <= rem_in - trial;
            root_r[k] <= root_in | (rmq_pkg::ROOT_W'(1) << B);
          end else begin
            rem_r[k]  <= rem_in;
            root_r[k] <= root_in;
          end
        end
      end
    end
  endgenerate

  assign root = root_r[rmq_pkg::ROOT_W-1];

endmodule

### src/rmq_div.sv
// Pipelined restoring divider: p * 2^FRAC_BITS / (4h), truncated toward zero.
`timescale 1ns / 1ps
module rmq_div (
  input  logic                              clk,
  input  logic                              en,
  input  logic signed [rmq_pkg::P_W-1:0]    p,
  input  logic [rmq_pkg::ROOT_W-1:0]        h,
  output logic [rmq_pkg::Q_W-1:0]           quo_mag,
  output logic                              quo_neg
);

  logic signed [rmq_pkg::P_W:0] p_ext;
  logic [rmq_pkg::P_W-1:0]      p_mag;

  logic [rmq_pkg::CMP_W-1:0] num_r;
  logic [rmq_pkg::DEN_W-1:0] den0_r;
  logic                      neg0_r;

  logic [rmq_pkg::CMP_W-1:0] rem_r [rmq_pkg::Q_W];
  logic [rmq_pkg::Q_W-1:0]   q_r   [rmq_pkg::Q_W];
  logic [rmq_pkg::DEN_W-1:0] den_r [rmq_pkg::Q_W];
  logic                      neg_r [rmq_pkg::Q_W];

  // Split the numerator into sign and magnitude.
  always_comb begin
    p_ext = (rmq_pkg::P_W + 1)'(p);
    p_mag = p_ext[rmq_pkg::P_W] ? rmq_pkg::P_W'(-p_ext) : rmq_pkg::P_W'(p_ext);
  end

  always_ff @(posedge clk) begin
    if (en) begin
      num_r  <= rmq_pkg::CMP_W'(p_mag) << rmq_pkg::FRAC_BITS;
      den0_r <= {h, 2'b00};
      neg0_r <= p[rmq_pkg::P_W-1];
    end
  end

  genvar k;
  generate
    for (k = 0; k < rmq_pkg::Q_W; k++) begin : g_stage
      localparam int B = rmq_pkg::Q_W - 1 - k;
      logic [rmq_pkg::CMP_W-1:0] rem_in;
      logic [rmq_pkg::Q_W-1:0]   q_in;
      logic [rmq_pkg::DEN_W-1:0] den_in;
      logic                      neg_in;
      logic [rmq_pkg::CMP_W-1:0] trial;

      if (k == 0) begin : g_first
        assign rem_in = num_r;
        assign q_in   = '0;
        assign den_in = den0_r;
        assign neg_in = neg0_r;
      end else begin : g_next
        assign rem_in = rem_r[k-1];
        assign q_in   = q_r[k-1];
        assign den_in = den_r[k-1];
        assign neg_in = neg_r[k-1];
      end

      // Divisor aligned to this quotient bit.
      assign trial = rmq_pkg::CMP_W'(den_in) << B;

      always_ff @(posedge clk) begin
        if (en) begin
          den_r[k] <= den_in;
          neg_r[k] <= neg_in;
          if (rem_in >= trial) begin
            rem_r[k] <= rem_in - trial;
            q_r[k]   <= q_in | (rmq_pkg::Q_W'(1) << B);
          end else begin
            rem_r[k] <= rem_in;
            q_r[k]   <= q_in;
          end
        end
      end
    end
  endgenerate

  assign quo_mag = q_r[rmq_pkg::Q_W-1];
  assign quo_neg = neg_r[rmq_pkg::Q_W-1];

endmodule

### src/rotation_matrix_to_quaternion.sv
// Top level: rotation matrix to unit quaternion, Shepperd's method, pipelined.
//
// The input channel takes one 3x3 matrix per word on in_tdata, nine signed Q2.14
// elements from m00 in the lowest bits to m22 in the highest. The output channel
// gives one word per matrix: quat_w, quat_x, quat_y, quat_z on out_tdata (signed
// Q2.14, saturated) and the branch code on out_tuser (0 trace, 1 m00 largest,
// 2 m11 largest, 3 m22 largest; a tie goes to the later diagonal element).
// The pipeline has a first stage that picks the branch and forms the radicand and
// the numerators, 15 square root stages (one root bit each), one divider setup
// stage, 24 divider stages (one quotient bit each, three lanes side by side) and
// one output stage for sign, saturation and placement.
// Throughput is one matrix per cycle while the receiver does not stall.
// Reset clears all valid bits; the pipeline then holds no words.
// When the receiver stalls with a word waiting, the whole pipeline freezes and
// in_tready drops; nothing is lost or repeated. While the output is empty or
// being taken, a new word is accepted every cycle.
`timescale 1ns / 1ps
`include "rotation_matrix_to_quaternion_defines.svh"
module rotation_matrix_to_quaternion (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         in_tvalid,
  output logic         in_tready,
  input  logic [143:0] in_tdata,   // m00, m01, m02, m10, m11, m12, m20, m21, m22
  output logic         out_tvalid,
  input  logic         out_tready,
  output logic [63:0]  out_tdata,  // quat_w, quat_x, quat_y, quat_z
  output logic [1:0]   out_tuser   // case_taken
);

  localparam int DW = rmq_pkg::DATA_W;

  logic en;
  logic [rmq_pkg::LAT-1:0] vld_r;
  logic [rmq_pkg::LAT-1:0] vld_nxt;

  logic signed [DW-1:0] a00, a01, a02, a10, a11, a12, a20, a21, a22;
  logic signed [DW+2:0] t_sum, u_sum;
  logic [1:0]           sel;
  logic signed [rmq_pkg::P_W-1:0] pa, pb, pc;
  logic [rmq_pkg::RAD_W-1:0]      rad;

  rmq_pkg::side_t side_r [rmq_pkg::ROOT_W+1];
  logic [rmq_pkg::RAD_W-1:0] rad_r;
  logic [rmq_pkg::ROOT_W-1:0] root;
  rmq_pkg::tail_t tail_r [rmq_pkg::Q_W+1];

  logic [rmq_pkg::Q_W-1:0] mag_a, mag_b, mag_c;
  logic neg_a, neg_b, neg_c;
  logic signed [DW-1:0] qa, qb, qc, qh;
  logic signed [DW-1:0] qw, qx, qy, qz;
  logic [63:0] out_tdata_r;
  logic [1:0]  out_tuser_r;

  // The pipeline advances whenever the output word is empty or being taken.
  assign en        = !vld_r[rmq_pkg::LAT-1] || out_tready;
  assign in_tready = en;

  assign vld_nxt = {vld_r[rmq_pkg::LAT-2:0], in_tvalid};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else if (en) begin
      vld_r <= vld_nxt;
    end
  end

  // Unpack the matrix.
  assign a00 = in_tdata[15:0];
  assign a01 = in_tdata[31:16];
  assign a02 = in_tdata[47:32];
  assign a10 = in_tdata[63:48];
  assign a11 = in_tdata[79:64];
  assign a12 = in_tdata[95:80];
  assign a20 = in_tdata[111:96];
  assign a21 = in_tdata[127:112];
  assign a22 = in_tdata[143:128];

  // Branch choice, radicand and numerators.
  always_comb begin
    t_sum = (DW + 3)'(1 << rmq_pkg::FRAC_BITS) + (DW + 3)'(a00) + (DW + 3)'(a11)
          + (DW + 3)'(a22);
    if (t_sum >= 1) begin
      sel   = rmq_pkg::SEL_TRACE;
      u_sum = t_sum;
      pa    = rmq_pkg::P_W'(a21) - rmq_pkg::P_W'(a12);
      pb    = rmq_pkg::P_W'(a02) - rmq_pkg::P_W'(a20);
      pc    = rmq_pkg::P_W'(a10) - rmq_pkg::P_W'(a01);
    end else if (a00 > a11 && a00 > a22) begin
      sel   = rmq_pkg::SEL_X;
      u_sum = (DW + 3)'(1 << rmq_pkg::FRAC_BITS) + (DW + 3)'(a00) - (DW + 3)'(a11)
            - (DW + 3)'(a22);
      pa    = rmq_pkg::P_W'(a21) - rmq_pkg::P_W'(a12);
      pb    = rmq_pkg::P_W'(a01) + rmq_pkg::P_W'(a10);
      pc    = rmq_pkg::P_W'(a02) + rmq_pkg::P_W'(a20);
    end else if (a11 > a22) begin
      sel   = rmq_pkg::SEL_Y;
      u_sum = (DW + 3)'(1 << rmq_pkg::FRAC_BITS) + (DW + 3)'(a11) - (DW + 3)'(a00)
            - (DW + 3)'(a22);
      pa    = rmq_pkg::P_W'(a02) - rmq_pkg::P_W'(a20);
      pb    = rmq_pkg::P_W'(a01) + rmq_pkg::P_W'(a10);
      pc    = rmq_pkg::P_W'(a12) + rmq_pkg::P_W'(a21);
    end else begin
      sel   = rmq_pkg::SEL_Z;
      u_sum = (DW + 3)'(1 << rmq_pkg::FRAC_BITS) + (DW + 3)'(a22) - (DW + 3)'(a00)
            - (DW + 3)'(a11);
      pa    = rmq_pkg::P_W'(a10) - rmq_pkg::P_W'(a01);
      pb    = rmq_pkg::P_W'(a02) + rmq_pkg::P_W'(a20);
      pc    = rmq_pkg::P_W'(a12) + rmq_pkg::P_W'(a21);
    end
    // A radicand below one is forced to one so the divisor never vanishes.
    rad = (u_sum < 1) ? rmq_pkg::RAD_W'(1) : u_sum[rmq_pkg::RAD_W-1:0];
  end

  // First stage and the side delay line beside the square root.
  always_ff @(posedge clk) begin
    if (en) begin
      rad_r     <= rad;
      side_r[0] <= '{sel: sel, pa: pa, pb: pb, pc: pc};
      for (int i = 1; i <= rmq_pkg::ROOT_W; i++) begin
        side_r[i] <= side_r[i-1];
      end
    end
  end

  rmq_sqrt u_sqrt (
    .clk  (clk),
    .en   (en),
    .rad  (rad_r),
    .root (root)
  );

  // Three divider lanes share the root; the other two numerators follow.
  rmq_div u_div_a (
    .clk     (clk),
    .en      (en),
    .p       (side_r[rmq_pkg::ROOT_W].pa),
    .h       (root),
    .quo_mag (mag_a),
    .quo_neg (neg_a)
  );

  rmq_div u_div_b (
    .clk     (clk),
    .en      (en),
    .p       (side_r[rmq_pkg::ROOT_W].pb),
    .h       (root),
    .quo_mag (mag_b),
    .quo_neg (neg_b)
  );

  rmq_div u_div_c (
    .clk     (clk),
    .en      (en),
    .p       (side_r[rmq_pkg::ROOT_W].pc),
    .h       (root),
    .quo_mag (mag_c),
    .quo_neg (neg_c)
  );

  // Branch code and root wait beside the dividers.
  always_ff @(posedge clk) begin
    if (en) begin
      tail_r[0] <= '{sel: side_r[rmq_pkg::ROOT_W].sel, h: root};
      for (int i = 1; i <= rmq_pkg::Q_W; i++) begin
        tail_r[i] <= tail_r[i-1];
      end
    end
  end

  // Saturate a signed quotient given as sign and magnitude.
  function automatic logic signed [DW-1:0] sat_q(input logic [rmq_pkg::Q_W-1:0] mag,
                                                 input logic neg);
    logic [rmq_pkg::Q_W-1:0] lim;
    lim = rmq_pkg::Q_W'(1) << (DW - 1);
    if (neg) begin
      sat_q = (mag >= lim) ? DW'(lim) : DW'(-mag);
    end else begin
      sat_q = (mag >= lim) ? DW'(lim - 1) : DW'(mag);
    end
  endfunction

  // Place the root and the three quotients by branch.
  always_comb begin
    qa = sat_q(mag_a, neg_a);
    qb = sat_q(mag_b, neg_b);
    qc = sat_q(mag_c, neg_c);
    qh = DW'(tail_r[rmq_pkg::Q_W].h);
    case (tail_r[rmq_pkg::Q_W].sel)
      rmq_pkg::SEL_TRACE: begin
        qw = qh; qx = qa; qy = qb; qz = qc;
      end
      rmq_pkg::SEL_X: begin
        qw = qa; qx = qh; qy = qb; qz = qc;
      end
      rmq_pkg::SEL_Y: begin
        qw = qa; qx = qb; qy = qh; qz = qc;
      end
      default: begin
        qw = qa; qx = qb; qy = qc; qz = qh;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (en) begin
      out_tdata_r <= {qz, qy, qx, qw};
      out_tuser_r <= tail_r[rmq_pkg::Q_W].sel;
    end
  end

  assign out_tvalid = vld_r[rmq_pkg::LAT-1];
  assign out_tdata  = out_tdata_r;
  assign out_tuser  = out_tuser_r;

  // The scalar of the trace branch is a root and never negative.
  `RMQ_ASSERT_NOW(a_trace_w_pos, out_tvalid && out_tuser == rmq_pkg::SEL_TRACE, !out_tdata[15], "trace branch gave a negative w")
  // In the x branch the root lands in x.
  `RMQ_ASSERT_NOW(a_x_root_pos, out_tvalid && out_tuser == rmq_pkg::SEL_X, !out_tdata[31], "x branch gave a negative x")
  // A stall freezes the whole valid chain.
  `RMQ_ASSERT_NEXT(a_stall_frozen, !in_tready, $stable(vld_r), "pipeline moved during a stall")
  // The root never drops below the value for a radicand of one.
  `RMQ_ASSERT_NOW(a_root_min, vld_r[rmq_pkg::ROOT_W], root >= rmq_pkg::ROOT_W'(64), "root below the floor of the radicand")

endmodule
